### rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define PMPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PMPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked after a delay from the antecedent
`define PMPC_ASSERT_TWO(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

### rtl/pmpc_pkg.sv
package pmpc_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 10;
    localparam int PERM_W     = 16;
    localparam int MASK_W     = 64;
    localparam int BC_W       = 11;
    localparam int IC_W       = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [CMD_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] KIND_RUN  = 2'd1;
    localparam logic [CMD_W-1:0] KIND_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_COUNT  = 1'd1;

    localparam logic [BC_W-1:0] BC_RESET = 11'd1024;
    localparam logic [IC_W-1:0] IC_RESET = 16'd1;

    typedef struct packed {
        logic base;
        logic cur;
        logic nxt;
    } t_tbl_we;

    typedef struct packed {
        logic busy;
        logic running;
    } t_seq_status;

endpackage

### rtl/pmpc_in_if.sv
interface pmpc_in_if;
    logic                          valid;
    logic                          ready;
    logic [pmpc_pkg::CMD_W-1:0]    cmd;
    logic [pmpc_pkg::IDX_W-1:0]    index;
    logic [pmpc_pkg::PERM_W-1:0]   perm_value;
    logic [pmpc_pkg::MASK_W-1:0]   mask_value;

    modport source (output valid, cmd, index, perm_value, mask_value, input ready);
    modport sink   (input valid, cmd, index, perm_value, mask_value, output ready);
endinterface

### rtl/pmpc_out_if.sv
interface pmpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [pmpc_pkg::CMD_W-1:0]    kind;
    logic [pmpc_pkg::PERM_W-1:0]   perm_result;
    logic [pmpc_pkg::MASK_W-1:0]   mask_result;

    modport source (output valid, kind, perm_result, mask_result, input ready);
    modport sink   (input valid, kind, perm_result, mask_result, output ready);
endinterface

### rtl/pmpc_tables.sv
module pmpc_tables #(
    parameter int MAX_BLOCKS = pmpc_pkg::MAX_BLOCKS_DEF,
    parameter int AW         = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic                        i_clk,
    input  pmpc_pkg::t_tbl_we           i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [pmpc_pkg::PERM_W-1:0] i_wperm,
    input  logic [pmpc_pkg::MASK_W-1:0] i_wmask,
    input  logic [AW-1:0]               i_bp_raddr,
    input  logic [AW-1:0]               i_bm_raddr,
    input  logic [AW-1:0]               i_cp_raddr,
    input  logic [AW-1:0]               i_cm_raddr,
    input  logic [AW-1:0]               i_nx_raddr,
    output logic [pmpc_pkg::PERM_W-1:0] o_bp_rdata,
    output logic [pmpc_pkg::MASK_W-1:0] o_bm_rdata,
    output logic [pmpc_pkg::PERM_W-1:0] o_cp_rdata,
    output logic [pmpc_pkg::MASK_W-1:0] o_cm_rdata,
    output logic [pmpc_pkg::PERM_W-1:0] o_np_rdata,
    output logic [pmpc_pkg::MASK_W-1:0] o_nm_rdata
);

    logic [pmpc_pkg::PERM_W-1:0] r_base_perm [MAX_BLOCKS];
    logic [pmpc_pkg::MASK_W-1:0] r_base_mask [MAX_BLOCKS];
    logic [pmpc_pkg::PERM_W-1:0] r_cur_perm  [MAX_BLOCKS];
    logic [pmpc_pkg::MASK_W-1:0] r_cur_mask  [MAX_BLOCKS];
    logic [pmpc_pkg::PERM_W-1:0] r_nxt_perm  [MAX_BLOCKS];
    logic [pmpc_pkg::MASK_W-1:0] r_nxt_mask  [MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_we.base) begin
            r_base_perm[i_waddr] <= i_wperm;
            r_base_mask[i_waddr] <= i_wmask;
        end
        o_bp_rdata <= r_base_perm[i_bp_raddr];
        o_bm_rdata <= r_base_mask[i_bm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.cur) begin
            r_cur_perm[i_waddr] <= i_wperm;
            r_cur_mask[i_waddr] <= i_wmask;
        end
        o_cp_rdata <= r_cur_perm[i_cp_raddr];
        o_cm_rdata <= r_cur_mask[i_cm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.nxt) begin
            r_nxt_perm[i_waddr] <= i_wperm;
            r_nxt_mask[i_waddr] <= i_wmask;
        end
        o_np_rdata <= r_nxt_perm[i_nx_raddr];
        o_nm_rdata <= r_nxt_mask[i_nx_raddr];
    end

endmodule

### rtl/pmpc_seq.sv
module pmpc_seq #(
    parameter int MAX_BLOCKS = pmpc_pkg::MAX_BLOCKS_DEF,
    parameter int AW         = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pmpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pmpc_in_if.sink                         i_in,
    pmpc_out_if.source                      o_out,
    output pmpc_pkg::t_tbl_we               o_we,
    output logic [AW-1:0]                   o_waddr,
    output logic [pmpc_pkg::PERM_W-1:0]     o_wperm,
    output logic [pmpc_pkg::MASK_W-1:0]     o_wmask,
    output logic [AW-1:0]                   o_bp_raddr,
    output logic [AW-1:0]                   o_bm_raddr,
    output logic [AW-1:0]                   o_cp_raddr,
    output logic [AW-1:0]                   o_cm_raddr,
    output logic [AW-1:0]                   o_nx_raddr,
    input  logic [pmpc_pkg::PERM_W-1:0]     i_bp_rdata,
    input  logic [pmpc_pkg::MASK_W-1:0]     i_bm_rdata,
    input  logic [pmpc_pkg::PERM_W-1:0]     i_cp_rdata,
    input  logic [pmpc_pkg::MASK_W-1:0]     i_cm_rdata,
    input  logic [pmpc_pkg::PERM_W-1:0]     i_np_rdata,
    input  logic [pmpc_pkg::MASK_W-1:0]     i_nm_rdata,
    output pmpc_pkg::t_seq_status           o_status
);

    localparam int NW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = 4;

    localparam logic [SW-1:0] ST_IDLE  = 4'd0;
    localparam logic [SW-1:0] ST_READ  = 4'd1;
    localparam logic [SW-1:0] ST_CP_RD = 4'd2;
    localparam logic [SW-1:0] ST_CP_WR = 4'd3;
    localparam logic [SW-1:0] ST_A     = 4'd4;
    localparam logic [SW-1:0] ST_B     = 4'd5;
    localparam logic [SW-1:0] ST_C     = 4'd6;
    localparam logic [SW-1:0] ST_CB_RD = 4'd7;
    localparam logic [SW-1:0] ST_CB_WR = 4'd8;
    localparam logic [SW-1:0] ST_DONE  = 4'd9;

    logic [SW-1:0]                   r_state, n_state;
    logic [NW-1:0]                   r_i, n_i;
    logic [NW-1:0]                   r_n, n_n;
    logic [pmpc_pkg::IC_W-1:0]       r_step, n_step;
    logic                            r_changed, n_changed;
    logic                            r_rd_oor, n_rd_oor;
    logic [pmpc_pkg::PERM_W-1:0]     r_p, n_p;
    logic [pmpc_pkg::MASK_W-1:0]     r_cm_i, n_cm_i;
    logic [pmpc_pkg::BC_W-1:0]       r_bc;
    logic [pmpc_pkg::IC_W-1:0]       r_ic;
    logic                            r_out_valid;
    logic [pmpc_pkg::CMD_W-1:0]      r_out_kind, n_out_kind;
    logic [pmpc_pkg::PERM_W-1:0]     r_out_perm, n_out_perm;
    logic [pmpc_pkg::MASK_W-1:0]     r_out_mask, n_out_mask;

    logic                            out_free;
    logic                            out_load;
    logic                            in_fire;
    logic                            idx_ok;
    logic [NW-1:0]                   run_n;
    logic [NW-1:0]                   i_inc;
    logic                            i_last;
    logic [AW-1:0]                   i_addr;
    logic                            p_ok;
    logic [pmpc_pkg::PERM_W-1:0]     nx_perm;
    logic [pmpc_pkg::MASK_W-1:0]     nx_mask;
    logic                            diff;
    logic [pmpc_pkg::IC_W:0]         step_inc;

    assign out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && out_free;
    assign in_fire   = i_in.valid && i_in.ready;
    assign idx_ok    = 32'(i_in.index) < 32'(MAX_BLOCKS);
    assign run_n     = (32'(r_bc) > 32'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : NW'(r_bc);
    assign i_inc     = r_i + NW'(1);
    assign i_last    = (i_inc == r_n);
    assign i_addr    = r_i[AW-1:0];
    assign p_ok      = 32'(r_p) < 32'(r_n);
    assign nx_perm   = p_ok ? i_bp_rdata : pmpc_pkg::PERM_W'(r_i);
    assign nx_mask   = p_ok ? (i_cm_rdata ^ i_bm_rdata) : r_cm_i;
    assign diff      = (nx_perm != r_p) || (nx_mask != r_cm_i);
    assign step_inc  = {1'b0, r_step} + (pmpc_pkg::IC_W+1)'(1);

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_n        = r_n;
        n_step     = r_step;
        n_changed  = r_changed;
        n_rd_oor   = r_rd_oor;
        n_p        = r_p;
        n_cm_i     = r_cm_i;
        out_load   = 1'b0;
        n_out_kind = r_out_kind;
        n_out_perm = '0;
        n_out_mask = '0;
        o_we       = '0;
        o_waddr    = i_addr;
        o_wperm    = i_bp_rdata;
        o_wmask    = i_bm_rdata;
        o_bp_raddr = i_addr;
        o_bm_raddr = i_addr;
        o_cp_raddr = i_addr;
        o_cm_raddr = i_addr;
        o_nx_raddr = i_addr;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.cmd)
                        pmpc_pkg::CMD_LOAD: begin
                            o_we.base  = idx_ok;
                            o_waddr    = AW'(i_in.index);
                            o_wperm    = i_in.perm_value;
                            o_wmask    = i_in.mask_value;
                            out_load   = 1'b1;
                            n_out_kind = pmpc_pkg::KIND_LOAD;
                        end
                        pmpc_pkg::CMD_RUN: begin
                            n_n = run_n;
                            n_i = '0;
                            if (run_n == '0) begin
                                out_load   = 1'b1;
                                n_out_kind = pmpc_pkg::KIND_RUN;
                            end else begin
                                n_state = ST_CP_RD;
                            end
                        end
                        pmpc_pkg::CMD_READ: begin
                            o_cp_raddr = AW'(i_in.index);
                            o_cm_raddr = AW'(i_in.index);
                            n_rd_oor   = !idx_ok;
                            n_state    = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_kind = pmpc_pkg::KIND_READ;
                    n_out_perm = r_rd_oor ? '0 : i_cp_rdata;
                    n_out_mask = r_rd_oor ? '0 : i_cm_rdata;
                    n_state    = ST_IDLE;
                end
            end
            ST_CP_RD: begin
                n_state = ST_CP_WR;
            end
            ST_CP_WR: begin
                o_we.cur = 1'b1;
                n_i      = i_inc;
                n_state  = ST_CP_RD;
                if (i_last) begin
                    n_i       = '0;
                    n_step    = pmpc_pkg::IC_W'(1);
                    n_changed = 1'b0;
                    n_state   = (r_ic <= pmpc_pkg::IC_W'(1)) ? ST_DONE : ST_A;
                end
            end
            ST_A: begin
                n_state = ST_B;
            end
            ST_B: begin
                n_p        = i_cp_rdata;
                n_cm_i     = i_cm_rdata;
                o_bp_raddr = AW'(i_cp_rdata);
                o_cm_raddr = AW'(i_cp_rdata);
                n_state    = ST_C;
            end
            ST_C: begin
                o_we.nxt  = 1'b1;
                o_wperm   = nx_perm;
                o_wmask   = nx_mask;
                n_changed = r_changed | diff;
                n_i       = i_inc;
                n_state   = ST_A;
                if (i_last) begin
                    n_i     = '0;
                    n_state = (r_changed | diff) ? ST_CB_RD : ST_DONE;
                end
            end
            ST_CB_RD: begin
                n_state = ST_CB_WR;
            end
            ST_CB_WR: begin
                o_we.cur = 1'b1;
                o_wperm  = i_np_rdata;
                o_wmask  = i_nm_rdata;
                n_i      = i_inc;
                n_state  = ST_CB_RD;
                if (i_last) begin
                    n_i       = '0;
                    n_step    = step_inc[pmpc_pkg::IC_W-1:0];
                    n_changed = 1'b0;
                    n_state   = (step_inc >= {1'b0, r_ic}) ? ST_DONE : ST_A;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_kind = pmpc_pkg::KIND_RUN;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bc        <= pmpc_pkg::BC_RESET;
            r_ic        <= pmpc_pkg::IC_RESET;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pmpc_pkg::CFG_BLOCK_COUNT: r_bc <= i_cfg_data[pmpc_pkg::BC_W-1:0];
                    pmpc_pkg::CFG_ITER_COUNT:  r_ic <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_n       <= n_n;
        r_step    <= n_step;
        r_changed <= n_changed;
        r_rd_oor  <= n_rd_oor;
        r_p       <= n_p;
        r_cm_i    <= n_cm_i;
        if (out_load) begin
            r_out_kind <= n_out_kind;
            r_out_perm <= n_out_perm;
            r_out_mask <= n_out_mask;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out_kind;
    assign o_out.perm_result = r_out_perm;
    assign o_out.mask_result = r_out_mask;

    assign o_status.busy    = (r_state != ST_IDLE);
    assign o_status.running = (r_state != ST_IDLE) && (r_state != ST_READ);

endmodule

### rtl/permutation_mask_power_composer.sv
// channel | dir | beat contents
// i_in    | in  | cmd, index, perm_value, mask_value
// o_out   | out | kind, perm_result, mask_result
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data (no handshake)
//
// load: base table written if the index is in range, result beat registered the next cycle
// read: table read registered, result beat loaded in ST_READ once the result slot is free
// run: copy, then per step compose and copy-back, each over n entries,
//   n = min(block_count, MAX_BLOCKS); stops early once a step changes nothing
// the compose pass is bound by one read port per table; input stalls during a run
// synchronous active-low reset clears control and config, tables are not cleared
`include "assert_macros.svh"

module permutation_mask_power_composer #(
    parameter int MAX_BLOCKS = pmpc_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pmpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pmpc_in_if.sink                         i_in,
    pmpc_out_if.source                      o_out
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    pmpc_pkg::t_tbl_we           we;
    pmpc_pkg::t_seq_status       status;
    logic [AW-1:0]               waddr;
    logic [pmpc_pkg::PERM_W-1:0] wperm;
    logic [pmpc_pkg::MASK_W-1:0] wmask;
    logic [AW-1:0]               bp_raddr, bm_raddr, cp_raddr, cm_raddr, nx_raddr;
    logic [pmpc_pkg::PERM_W-1:0] bp_rdata, cp_rdata, np_rdata;
    logic [pmpc_pkg::MASK_W-1:0] bm_rdata, cm_rdata, nm_rdata;

    pmpc_seq #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wperm    (wperm),
        .o_wmask    (wmask),
        .o_bp_raddr (bp_raddr),
        .o_bm_raddr (bm_raddr),
        .o_cp_raddr (cp_raddr),
        .o_cm_raddr (cm_raddr),
        .o_nx_raddr (nx_raddr),
        .i_bp_rdata (bp_rdata),
        .i_bm_rdata (bm_rdata),
        .i_cp_rdata (cp_rdata),
        .i_cm_rdata (cm_rdata),
        .i_np_rdata (np_rdata),
        .i_nm_rdata (nm_rdata),
        .o_status   (status)
    );

    pmpc_tables #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW)
    ) u_tables (
        .i_clk      (i_clk),
        .i_we       (we),
        .i_waddr    (waddr),
        .i_wperm    (wperm),
        .i_wmask    (wmask),
        .i_bp_raddr (bp_raddr),
        .i_bm_raddr (bm_raddr),
        .i_cp_raddr (cp_raddr),
        .i_cm_raddr (cm_raddr),
        .i_nx_raddr (nx_raddr),
        .o_bp_rdata (bp_rdata),
        .o_bm_rdata (bm_rdata),
        .o_cp_rdata (cp_rdata),
        .o_cm_rdata (cm_rdata),
        .o_np_rdata (np_rdata),
        .o_nm_rdata (nm_rdata)
    );

    `PMPC_ASSERT_NOW(a_busy_stalls_in, i_clk, i_rst_n, status.busy, !i_in.ready, "input taken while busy")
    `PMPC_ASSERT_NOW(a_ready_needs_slot, i_clk, i_rst_n, i_in.ready, (!o_out.valid || o_out.ready), "input taken with result slot blocked")
    `PMPC_ASSERT_NEXT(a_load_ack, i_clk, i_rst_n, (i_in.valid && i_in.ready && i_in.cmd == pmpc_pkg::CMD_LOAD), (o_out.valid && o_out.kind == pmpc_pkg::KIND_LOAD), "load beat not acknowledged")
    `PMPC_ASSERT_TWO(a_read_data, i_clk, i_rst_n, (i_in.valid && i_in.ready && i_in.cmd == pmpc_pkg::CMD_READ), (o_out.valid && o_out.kind == pmpc_pkg::KIND_READ), "read beat not answered")
    `PMPC_ASSERT_NOW(a_run_no_read, i_clk, i_rst_n, status.running, !o_out.valid || o_out.kind != pmpc_pkg::KIND_READ || !$rose(o_out.valid), "read data raised during run")

endmodule

### dv/pmpc_power_checker.sv
module pmpc_power_checker
    import pmpc_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pmpc_in_if                    i_in_mon,
    pmpc_out_if                   i_out_mon,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [CMD_W-1:0]  kind;
        logic [PERM_W-1:0] perm;
        logic [MASK_W-1:0] mask;
    } answer_t;

    answer_t awaited_answers[$];
    int      fail_count = 0;

    logic [BC_W-1:0]   block_count;
    logic [IC_W-1:0]   iter_count;

    logic [PERM_W-1:0] base_perm [MAX_BLOCKS];
    logic [MASK_W-1:0] base_mask [MAX_BLOCKS];
    logic [PERM_W-1:0] cur_perm  [MAX_BLOCKS];
    logic [MASK_W-1:0] cur_mask  [MAX_BLOCKS];
    logic [PERM_W-1:0] nxt_perm  [MAX_BLOCKS];
    logic [MASK_W-1:0] nxt_mask  [MAX_BLOCKS];

    // composed map = base map raised to max(iter_count, 1), stopping once a step is a fixed point
    task automatic raise_to_power();
        int n;
        int p;
        bit settled;
        n = int'(block_count);
        if (n == 0)
            return;
        if (n > MAX_BLOCKS)
            n = MAX_BLOCKS;
        for (int i = 0; i < n; i++) begin
            cur_perm[i] = base_perm[i];
            cur_mask[i] = base_mask[i];
        end
        for (int step = 1; step < int'(iter_count); step++) begin
            settled = 1'b1;
            for (int i = 0; i < n; i++) begin
                p = int'(cur_perm[i]);
                if (p < n) begin
                    nxt_perm[i] = base_perm[p];
                    nxt_mask[i] = cur_mask[p] ^ base_mask[i];
                end else begin
                    nxt_perm[i] = PERM_W'(i);
                    nxt_mask[i] = cur_mask[i];
                end
                if (nxt_perm[i] !== cur_perm[i] || nxt_mask[i] !== cur_mask[i])
                    settled = 1'b0;
            end
            if (settled)
                break;
            for (int i = 0; i < n; i++) begin
                cur_perm[i] = nxt_perm[i];
                cur_mask[i] = nxt_mask[i];
            end
        end
    endtask

    task automatic predict_answer(input logic [CMD_W-1:0]  cmd,
                                  input logic [IDX_W-1:0]  idx,
                                  input logic [PERM_W-1:0] pv,
                                  input logic [MASK_W-1:0] mv);
        case (cmd)
            CMD_LOAD: begin
                if (int'(idx) < MAX_BLOCKS) begin
                    base_perm[idx] = pv;
                    base_mask[idx] = mv;
                end
                awaited_answers.push_back(answer_t'{KIND_LOAD, '0, '0});
            end
            CMD_RUN: begin
                raise_to_power();
                awaited_answers.push_back(answer_t'{KIND_RUN, '0, '0});
            end
            CMD_READ: begin
                if (int'(idx) < MAX_BLOCKS)
                    awaited_answers.push_back(answer_t'{KIND_READ, cur_perm[idx], cur_mask[idx]});
                else
                    awaited_answers.push_back(answer_t'{KIND_READ, '0, '0});
            end
            default: ;
        endcase
    endtask

    function automatic void compare_field(string name, logic [MASK_W-1:0] want,
                                          logic [MASK_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        answer_t got;
        answer_t want;
        if (!i_rst_n) begin
            block_count = BC_RESET;
            iter_count  = IC_RESET;
            awaited_answers.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_COUNT: block_count = i_cfg_data[BC_W-1:0];
                    CFG_ITER_COUNT:  iter_count  = i_cfg_data[IC_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict_answer(i_in_mon.cmd, i_in_mon.index, i_in_mon.perm_value,
                               i_in_mon.mask_value);
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = answer_t'{i_out_mon.kind, i_out_mon.perm_result, i_out_mon.mask_result};
                if (awaited_answers.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing awaited, expected none actual kind %0h",
                             $time, got.kind);
                end else begin
                    want = awaited_answers.pop_front();
                    compare_field("kind", MASK_W'(want.kind), MASK_W'(got.kind));
                    compare_field("perm_result", MASK_W'(want.perm), MASK_W'(got.perm));
                    compare_field("mask_result", want.mask, got.mask);
                end
            end
        end
        o_fail_count = fail_count;
        o_pending    = awaited_answers.size();
    end

endmodule

### dv/tb_permutation_mask_power_composer.sv
module tb_permutation_mask_power_composer;
    import pmpc_pkg::*;

    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int BLOCKS        = MAX_BLOCKS_DEF;
    localparam int WARM_BLOCKS   = 64;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 30;

    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  no_gaps;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;

    pmpc_in_if  in_bus ();
    pmpc_out_if out_bus ();

    permutation_mask_power_composer i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    pmpc_power_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        out_bus.ready <= no_gaps || ($urandom_range(0, 99) >= 17);
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [MASK_W-1:0] random_mask();
        return {$urandom, $urandom};
    endfunction

    // mostly in range, some just past the end, some anywhere in the field
    function automatic logic [PERM_W-1:0] pick_perm(int n);
        case ($urandom_range(0, 9))
            0:       return PERM_W'($urandom_range(0, 65535));
            1:       return PERM_W'($urandom_range(n, n + 3));
            default: return PERM_W'($urandom_range(0, n - 1));
        endcase
    endfunction

    task automatic send_beat(input logic [CMD_W-1:0]  c,
                             input logic [IDX_W-1:0]  idx,
                             input logic [PERM_W-1:0] pv,
                             input logic [MASK_W-1:0] mv);
        while (!no_gaps && $urandom_range(0, 99) < 17) begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.cmd        <= c;
        in_bus.index      <= idx;
        in_bus.perm_value <= pv;
        in_bus.mask_value <= mv;
        do
            @(posedge clk);
        while (!in_bus.ready);
    endtask

    task automatic drain_results();
        in_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [BC_W-1:0] bc, input logic [IC_W-1:0] ic);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_BLOCK_COUNT;
        cfg_data <= CFG_DATA_W'(bc);
        @(posedge clk);
        cfg_idx  <= CFG_ITER_COUNT;
        cfg_data <= CFG_DATA_W'(ic);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic read_at(input int idx);
        send_beat(CMD_READ, IDX_W'(idx), pick_perm(BLOCKS), random_mask());
    endtask

    task automatic run_map();
        send_beat(CMD_RUN, IDX_W'($urandom_range(0, BLOCKS - 1)), pick_perm(BLOCKS),
                  random_mask());
    endtask

    initial begin
        int                n;
        int                sel;
        int                items;
        int                loads;
        int                reads;
        logic [IC_W-1:0]   ic;
        logic [CMD_W-1:0]  c;
        logic [PERM_W-1:0] pv;
        logic [MASK_W-1:0] mv;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_BLOCK_COUNT;
        cfg_data          <= '0;
        no_gaps           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.cmd        <= CMD_LOAD;
        in_bus.index      <= '0;
        in_bus.perm_value <= '0;
        in_bus.mask_value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // fill a small table so every later run and read sees loaded entries
        send_beat(CMD_IGNORED, '1, '1, '1);
        set_config(BC_W'(WARM_BLOCKS), IC_W'(3));
        for (int k = 0; k < WARM_BLOCKS; k++) begin
            if (k == 0) begin
                pv = '1;
                mv = '1;
            end else if (k == WARM_BLOCKS - 1) begin
                pv = '0;
                mv = '0;
            end else begin
                pv = pick_perm(WARM_BLOCKS);
                mv = random_mask();
            end
            send_beat(CMD_LOAD, IDX_W'(k), pv, mv);
        end
        run_map();
        read_at(0);
        read_at(WARM_BLOCKS - 1);
        read_at($urandom_range(1, WARM_BLOCKS - 2));
        send_beat(CMD_IGNORED, '0, '0, '0);

        // constant map onto a zero-mask fixed point settles after one step
        set_config(BC_W'(4), '1);
        for (int k = 0; k < 4; k++)
            send_beat(CMD_LOAD, IDX_W'(k), 16'd2, (k == 2) ? '0 : random_mask());
        run_map();
        for (int k = 0; k < 4; k++)
            read_at(k);

        // zero block count leaves the composed map alone
        set_config('0, IC_W'(5));
        run_map();
        for (int k = 0; k < 4; k++)
            read_at(k);
        read_at(WARM_BLOCKS - 1);

        set_config(BC_W'(1), '0);
        send_beat(CMD_LOAD, '0, '0, random_mask());
        run_map();
        read_at(0);
        read_at(1);

        set_config(BC_W'(1), '1);
        send_beat(CMD_LOAD, '0, '0, '0);
        send_beat(CMD_LOAD, '1, pick_perm(BLOCKS), random_mask());
        run_map();
        read_at(0);
        read_at(WARM_BLOCKS - 1);

        for (int phase = 0; phase < PHASES; phase++) begin
            sel = $urandom_range(0, 9);
            if (phase == 0 || sel == 0)
                n = 1;
            else if (sel == 1)
                n = $urandom_range(17, WARM_BLOCKS);
            else
                n = $urandom_range(2, 16);
            if (phase == 1)
                ic = '0;
            else if ($urandom_range(0, 3) == 0)
                ic = IC_W'($urandom_range(0, 1));
            else
                ic = IC_W'($urandom_range(2, 10));
            set_config(BC_W'(n), ic);
            no_gaps <= (phase == 2);
            items = 0;
            while (items < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7) begin
                    loads = $urandom_range(0, 4);
                    reads = $urandom_range(1, 4);
                    repeat (loads)
                        send_beat(CMD_LOAD, IDX_W'($urandom_range(0, n - 1)), pick_perm(n),
                                  random_mask());
                    run_map();
                    repeat (reads)
                        read_at($urandom_range(0, n - 1));
                    items += loads + 1 + reads;
                end else begin
                    c = CMD_W'($urandom_range(0, 3));
                    send_beat(c, IDX_W'($urandom_range(0, WARM_BLOCKS - 1)),
                              PERM_W'($urandom_range(0, 65535)), random_mask());
                    if (c != CMD_IGNORED)
                        items++;
                end
                if ($urandom_range(0, 24) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/pmpc_pkg.sv
rtl/pmpc_in_if.sv
rtl/pmpc_out_if.sv
rtl/pmpc_tables.sv
rtl/pmpc_seq.sv
rtl/permutation_mask_power_composer.sv
dv/pmpc_power_checker.sv
dv/tb_permutation_mask_power_composer.sv
